FILE: hdl/rsq_pkg.sv
package rsq_pkg;

   // Queue geometry.
   localparam int DEPTH       = 16;
   localparam int DATA_WIDTH  = 32;
   localparam int ADDR_WIDTH  = $clog2(DEPTH);
   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

   // Command codes carried in the request.
   localparam logic [1:0] CMD_ENQUEUE = 2'd0;
   localparam logic [1:0] CMD_DEQUEUE = 2'd1;
   localparam logic [1:0] CMD_REVERSE = 2'd2;
   localparam logic [1:0] CMD_STATUS  = 2'd3;

   typedef struct packed {
      logic [1:0]            command;
      logic [DATA_WIDTH-1:0] value;
   } req_type;

   typedef struct packed {
      logic                   accepted;
      logic [DATA_WIDTH-1:0]  head_out;
      logic [DATA_WIDTH-1:0]  tail_word;
      logic [COUNT_WIDTH-1:0] occupancy;
      logic                   is_empty;
      logic                   is_full;
   } rsp_type;

endpackage

FILE: hdl/reversible_shift_queue_core.sv
// Channel   Direction  Transfer condition           Payload
// request   in         start && !busy at clock edge req_data  (rsq_pkg::req_type)
// response  out        rsp_strobe, one cycle only   rsp_data  (rsq_pkg::rsp_type)
//
// The time from one request transfer to the next depends on the command. Enqueue,
// status and any refused command go straight to the tail read; a dequeue moves
// every remaining word down one slot, and a reverse swaps pairs of words from both
// ends. The sequencer moves one word of the slot memory per read or write state.
// Reset is synchronous and active high; it empties the queue and idles the
// sequencer. The slot memory is not cleared, as only occupied slots are read.
// The receiver cannot stall: each response is shown for exactly one cycle.
module reversible_shift_queue_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  rsq_pkg::req_type req_data,
   output logic             rsp_strobe,
   output rsq_pkg::rsp_type rsp_data
);

   // One-hot sequencer states.
   typedef enum logic [9:0] {
      S_IDLE    = 10'b00_0000_0001,
      S_DQ_CAP  = 10'b00_0000_0010,
      S_DQ_CHK  = 10'b00_0000_0100,
      S_DQ_WR   = 10'b00_0000_1000,
      S_RV_CHK  = 10'b00_0001_0000,
      S_RV_RDHI = 10'b00_0010_0000,
      S_RV_WRLO = 10'b00_0100_0000,
      S_RV_WRHI = 10'b00_1000_0000,
      S_TAIL    = 10'b01_0000_0000,
      S_RESP    = 10'b10_0000_0000
   } state_type;

   state_type                             state_ff, state_in;
   logic [rsq_pkg::COUNT_WIDTH-1:0]       count_ff, count_in;
   logic [rsq_pkg::ADDR_WIDTH-1:0]        idx_ff, idx_in;
   logic [rsq_pkg::ADDR_WIDTH-1:0]        hi_ff, hi_in;
   logic [rsq_pkg::DATA_WIDTH-1:0]        head_ff, head_in;
   logic [rsq_pkg::DATA_WIDTH-1:0]        tmp_ff, tmp_in;
   logic                                  ok_ff, ok_in;
   logic                                  rsp_strobe_ff, rsp_strobe_in;
   rsq_pkg::rsp_type                      rsp_data_ff, rsp_data_in;

   // Slot memory with one write and one registered read per cycle.
   logic [rsq_pkg::DATA_WIDTH-1:0]        mem [rsq_pkg::DEPTH];
   logic [rsq_pkg::DATA_WIDTH-1:0]        rd_data_ff;
   logic                                  rd_en;
   logic [rsq_pkg::ADDR_WIDTH-1:0]        rd_addr;
   logic                                  wr_en;
   logic [rsq_pkg::ADDR_WIDTH-1:0]        wr_addr;
   logic [rsq_pkg::DATA_WIDTH-1:0]        wr_data;

   logic                                  transfer;
   logic                                  is_empty;
   logic                                  is_full;
   logic [rsq_pkg::COUNT_WIDTH-1:0]       count_m1;
   logic [rsq_pkg::COUNT_WIDTH-1:0]       idx_p1;

   assign busy       = (state_ff != S_IDLE);
   assign transfer   = start && !busy;
   assign is_empty   = (count_ff == '0);
   assign is_full    = (count_ff == rsq_pkg::COUNT_WIDTH'(rsq_pkg::DEPTH));
   assign count_m1   = count_ff - rsq_pkg::COUNT_WIDTH'(1);
   assign idx_p1     = {1'b0, idx_ff} + rsq_pkg::COUNT_WIDTH'(1);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Sequencer. Each state drives at most one memory access, so the memory
   // port is the shared unit that every command works through.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      hi_in         = hi_ff;
      head_in       = head_ff;
      tmp_in        = tmp_ff;
      ok_in         = ok_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      rd_en         = 1'b0;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = req_data.value;

      case (state_ff)
         S_IDLE: begin
            if (transfer) begin
               head_in  = '0;
               ok_in    = 1'b0;
               state_in = S_TAIL;
               case (req_data.command)
                  rsq_pkg::CMD_ENQUEUE: begin
                     // The new word lands at the tail in the transfer cycle.
                     if (!is_full) begin
                        wr_en    = 1'b1;
                        wr_addr  = count_ff[rsq_pkg::ADDR_WIDTH-1:0];
                        count_in = count_ff + rsq_pkg::COUNT_WIDTH'(1);
                        ok_in    = 1'b1;
                     end
                  end
                  rsq_pkg::CMD_DEQUEUE: begin
                     if (!is_empty) begin
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        ok_in    = 1'b1;
                        state_in = S_DQ_CAP;
                     end
                  end
                  rsq_pkg::CMD_REVERSE: begin
                     if (!is_empty) begin
                        idx_in   = '0;
                        hi_in    = count_m1[rsq_pkg::ADDR_WIDTH-1:0];
                        ok_in    = 1'b1;
                        state_in = S_RV_CHK;
                     end
                  end
                  rsq_pkg::CMD_STATUS: begin
                     ok_in = 1'b1;
                  end
                  default: begin
                     ok_in = 1'b1;
                  end
               endcase
            end
         end

         S_DQ_CAP: begin
            head_in  = rd_data_ff;
            idx_in   = '0;
            state_in = S_DQ_CHK;
         end

         S_DQ_CHK: begin
            // Move slot idx+1 down to slot idx until the last occupied slot.
            if (idx_p1 < count_ff) begin
               rd_en    = 1'b1;
               rd_addr  = idx_p1[rsq_pkg::ADDR_WIDTH-1:0];
               state_in = S_DQ_WR;
            end else begin
               count_in = count_m1;
               state_in = S_TAIL;
            end
         end

         S_DQ_WR: begin
            wr_en    = 1'b1;
            wr_addr  = idx_ff;
            wr_data  = rd_data_ff;
            idx_in   = idx_p1[rsq_pkg::ADDR_WIDTH-1:0];
            state_in = S_DQ_CHK;
         end

         S_RV_CHK: begin
            // The low pointer lives in idx_ff; swap pairs until they meet.
            if (idx_ff < hi_ff) begin
               rd_en    = 1'b1;
               rd_addr  = idx_ff;
               state_in = S_RV_RDHI;
            end else begin
               state_in = S_TAIL;
            end
         end

         S_RV_RDHI: begin
            rd_en    = 1'b1;
            rd_addr  = hi_ff;
            tmp_in   = rd_data_ff;
            state_in = S_RV_WRLO;
         end

         S_RV_WRLO: begin
            wr_en    = 1'b1;
            wr_addr  = idx_ff;
            wr_data  = rd_data_ff;
            state_in = S_RV_WRHI;
         end

         S_RV_WRHI: begin
            wr_en    = 1'b1;
            wr_addr  = hi_ff;
            wr_data  = tmp_ff;
            idx_in   = idx_ff + rsq_pkg::ADDR_WIDTH'(1);
            hi_in    = hi_ff - rsq_pkg::ADDR_WIDTH'(1);
            state_in = S_RV_CHK;
         end

         S_TAIL: begin
            if (!is_empty) begin
               rd_en   = 1'b1;
               rd_addr = count_m1[rsq_pkg::ADDR_WIDTH-1:0];
            end
            state_in = S_RESP;
         end

         S_RESP: begin
            rsp_data_in.accepted  = ok_ff;
            rsp_data_in.head_out  = head_ff;
            rsp_data_in.tail_word = is_empty ? '0 : rd_data_ff;
            rsp_data_in.occupancy = count_ff;
            rsp_data_in.is_empty  = is_empty;
            rsp_data_in.is_full   = is_full;
            rsp_strobe_in         = 1'b1;
            state_in              = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      hi_ff       <= hi_in;
      head_ff     <= head_in;
      tmp_ff      <= tmp_in;
      ok_ff       <= ok_in;
      rsp_data_ff <= rsp_data_in;
   end

   // The occupancy never passes the depth.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= rsq_pkg::COUNT_WIDTH'(rsq_pkg::DEPTH))
      else $error("occupancy exceeds depth");

   // The response state is always followed by exactly one strobe.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP) |=> (rsp_strobe_ff && !busy))
      else $error("response state not followed by strobe");

   // An accepted enqueue raises the occupancy by one.
   assert property (@(posedge clock) disable iff (reset)
      (transfer && (req_data.command == rsq_pkg::CMD_ENQUEUE) && !is_full)
      |=> (count_ff == $past(count_ff) + rsq_pkg::COUNT_WIDTH'(1)))
      else $error("enqueue did not advance occupancy");

   // A swap is only started with the low pointer below the high one.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RV_RDHI) |-> (idx_ff < hi_ff))
      else $error("reverse swap with crossed pointers");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

class queue_scoreboard;
   logic [rsq_pkg::DATA_WIDTH-1:0] slots [rsq_pkg::DEPTH];
   int                             count;
   rsq_pkg::rsp_type               pending_rsp [$];
   int                             failures;
   int                             cmd_seen [4];
   int                             refused;
   int                             full_seen;
   int                             empty_seen;

   function new();
      count      = 0;
      failures   = 0;
      refused    = 0;
      full_seen  = 0;
      empty_seen = 0;
      foreach (cmd_seen[i]) cmd_seen[i] = 0;
      foreach (slots[i]) slots[i] = '0;
   endfunction

   // Applies one request that the block has taken to the shadow queue and stores the response it must give.
   function void note_request(rsq_pkg::req_type req);
      rsq_pkg::rsp_type               exp;
      logic [rsq_pkg::DATA_WIDTH-1:0] swap;
      int                             lo;
      int                             hi;
      exp = '0;
      cmd_seen[req.command]++;
      case (req.command)
         rsq_pkg::CMD_ENQUEUE: begin
            if (count < rsq_pkg::DEPTH) begin
               slots[count] = req.value;
               count++;
               exp.accepted = 1'b1;
            end
         end
         rsq_pkg::CMD_DEQUEUE: begin
            if (count > 0) begin
               exp.head_out = slots[0];
               for (int i = 0; i + 1 < count; i++) slots[i] = slots[i+1];
               count--;
               exp.accepted = 1'b1;
            end
         end
         rsq_pkg::CMD_REVERSE: begin
            if (count > 0) begin
               lo = 0;
               hi = count - 1;
               while (lo < hi) begin
                  swap      = slots[lo];
                  slots[lo] = slots[hi];
                  slots[hi] = swap;
                  lo++;
                  hi--;
               end
               exp.accepted = 1'b1;
            end
         end
         default: exp.accepted = 1'b1;
      endcase
      exp.tail_word = (count > 0) ? slots[count-1] : '0;
      exp.occupancy = count[rsq_pkg::COUNT_WIDTH-1:0];
      exp.is_empty  = (count == 0);
      exp.is_full   = (count == rsq_pkg::DEPTH);
      if (!exp.accepted) refused++;
      if (exp.is_full) full_seen++;
      if (exp.is_empty) empty_seen++;
      pending_rsp.push_back(exp);
   endfunction

   function void compare_field(string name, logic [31:0] exp_val, logic [31:0] got_val);
      if (exp_val !== got_val) begin
         $error("field %s: expected %0h, actual %0h", name, exp_val, got_val);
         failures++;
      end
   endfunction

   function void check_response(rsq_pkg::rsp_type got);
      rsq_pkg::rsp_type exp;
      if (pending_rsp.size() == 0) begin
         $error("response with no request outstanding: %p", got);
         failures++;
         return;
      end
      exp = pending_rsp.pop_front();
      compare_field("accepted", 32'(exp.accepted), 32'(got.accepted));
      compare_field("head_out", 32'(exp.head_out), 32'(got.head_out));
      compare_field("tail_word", 32'(exp.tail_word), 32'(got.tail_word));
      compare_field("occupancy", 32'(exp.occupancy), 32'(got.occupancy));
      compare_field("is_empty", 32'(exp.is_empty), 32'(got.is_empty));
      compare_field("is_full", 32'(exp.is_full), 32'(got.is_full));
   endfunction

   function int outstanding();
      return pending_rsp.size();
   endfunction
endclass

module tb;

   // Traffic profiles used by the random part: each one pushes the queue towards a
   // different region of its occupancy so that both full and empty are visited often.
   typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} traffic_mode_type;

   localparam int RANDOM_ITEMS = 850;
   localparam int BLOCK_ITEMS  = 50;
   localparam int CYCLE_LIMIT  = 300000;
   // The longest command is a reverse of a full queue, and this drain
   // margin comfortably covers any late or spurious response.
   localparam int DRAIN_CYCLES = 60;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   rsq_pkg::req_type req_data = '0;
   logic             rsp_strobe;
   rsq_pkg::rsp_type rsp_data;

   queue_scoreboard  sb = new();
   int               cycle_count = 0;
   bit               idling_on = 1'b1;

   reversible_shift_queue_core dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always #2 clock = ~clock;

   // The response channel cannot be held off, so every strobe is checked at the edge
   // that closes its single cycle. Values read here are those from before the edge.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         sb.check_response(rsp_data);
      end
   end

   // Watchdog: a hung sequencer or a lost response ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d responses outstanding",
                  cycle_count, sb.outstanding());
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Presents one request and holds it until the block takes it. Start is left high
   // afterwards, so that back-to-back requests never lower and raise it in one step;
   // only the idle task and the drain waits bring it down.
   task automatic send_request(input logic [1:0] cmd, input logic [31:0] val);
      rsq_pkg::req_type req;
      req.command = cmd;
      req.value   = val;
      req_data <= req;
      start    <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      // A transfer has happened at this edge: start was high and busy was low.
      sb.note_request(req);
   endtask

   task automatic idle_for(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Random idle gaps land on every phase of the multi-cycle sequencer,
   // since a request may be lowered and raised again while the block is still busy.
   task automatic maybe_idle();
      if (idling_on && $urandom_range(99) < 33) idle_for($urandom_range(1, 6));
   endtask

   // Holds the sender off until every outstanding response has come back. With
   // nothing outstanding, start has already been lowered by an idle gap.
   task automatic wait_drained();
      if (sb.outstanding() != 0) begin
         start <= 1'b0;
         while (sb.outstanding() != 0) @(posedge clock);
      end
   endtask

   function automatic logic [31:0] pick_value();
      int r;
      r = $urandom_range(99);
      if (r < 5) return '0;
      if (r < 10) return '1;
      return $urandom;
   endfunction

   function automatic logic [1:0] pick_command(traffic_mode_type mode);
      int r;
      r = $urandom_range(99);
      case (mode)
         MODE_FILL: begin
            if (r < 70) return rsq_pkg::CMD_ENQUEUE;
            if (r < 80) return rsq_pkg::CMD_DEQUEUE;
            if (r < 92) return rsq_pkg::CMD_REVERSE;
            return rsq_pkg::CMD_STATUS;
         end
         MODE_DRAIN: begin
            if (r < 20) return rsq_pkg::CMD_ENQUEUE;
            if (r < 75) return rsq_pkg::CMD_DEQUEUE;
            if (r < 90) return rsq_pkg::CMD_REVERSE;
            return rsq_pkg::CMD_STATUS;
         end
         default: begin
            if (r < 40) return rsq_pkg::CMD_ENQUEUE;
            if (r < 75) return rsq_pkg::CMD_DEQUEUE;
            if (r < 92) return rsq_pkg::CMD_REVERSE;
            return rsq_pkg::CMD_STATUS;
         end
      endcase
   endfunction

   initial begin
      traffic_mode_type mode;
      int               block;

      // Reset is held high at the start of the run, then released and never raised again.
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: every command on an empty queue, a reverse of a single word,
      // the extreme data words, a short reverse and a drain back to empty.
      send_request(rsq_pkg::CMD_DEQUEUE, 32'hFFFF_FFFF);
      send_request(rsq_pkg::CMD_REVERSE, 32'h0000_0000);
      send_request(rsq_pkg::CMD_STATUS,  32'h1234_5678);
      send_request(rsq_pkg::CMD_ENQUEUE, 32'h0000_0000);
      send_request(rsq_pkg::CMD_REVERSE, 32'h0000_0000);
      send_request(rsq_pkg::CMD_ENQUEUE, 32'hFFFF_FFFF);
      send_request(rsq_pkg::CMD_ENQUEUE, 32'hA5A5_5A5A);
      send_request(rsq_pkg::CMD_REVERSE, 32'h0000_0000);
      send_request(rsq_pkg::CMD_STATUS,  32'h0000_0000);
      send_request(rsq_pkg::CMD_DEQUEUE, 32'h0000_0000);
      send_request(rsq_pkg::CMD_DEQUEUE, 32'h0000_0000);
      send_request(rsq_pkg::CMD_DEQUEUE, 32'h0000_0000);
      send_request(rsq_pkg::CMD_DEQUEUE, 32'h0000_0000);
      // Filling to the brim, then an enqueue that must be refused and a full reverse.
      for (int i = 0; i < rsq_pkg::DEPTH; i++) begin
         send_request(rsq_pkg::CMD_ENQUEUE, $urandom);
      end
      send_request(rsq_pkg::CMD_ENQUEUE, 32'h5A5A_A5A5);
      send_request(rsq_pkg::CMD_REVERSE, 32'h0000_0000);

      // Random part, in blocks that each follow one traffic profile. Blocks four to
      // seven run with no idling at all, and after block eight the sender waits until
      // every response has come home before carrying on.
      for (block = 0; block < RANDOM_ITEMS / BLOCK_ITEMS; block++) begin
         mode      = traffic_mode_type'($urandom_range(2));
         idling_on = !(block >= 4 && block < 8);
         for (int i = 0; i < BLOCK_ITEMS; i++) begin
            send_request(pick_command(mode), pick_value());
            maybe_idle();
         end
         if (block == 8) wait_drained();
      end

      // Drain: wait for the last responses, then a further margin for stray strobes.
      wait_drained();
      start <= 1'b0;
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d enqueue, %0d dequeue, %0d reverse and %0d status transfers",
               sb.cmd_seen[rsq_pkg::CMD_ENQUEUE], sb.cmd_seen[rsq_pkg::CMD_DEQUEUE],
               sb.cmd_seen[rsq_pkg::CMD_REVERSE], sb.cmd_seen[rsq_pkg::CMD_STATUS]);
      $display("%0d refused, queue left full %0d times and empty %0d times",
               sb.refused, sb.full_seen, sb.empty_seen);
      if (sb.failures == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
